### rtl/assert_macros.svh
// Assertion macros for the histogram RTL, included by the back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/vehist_pkg.sv
// Shared constants, codes and item types of the variable edge histogram.
`default_nettype none

package vehist_pkg;

  localparam int LIMIT_SLOTS = 64;
  localparam int AGE_BOUND   = 200;
  localparam int LANES       = 8;
  localparam int ROWS        = LIMIT_SLOTS / LANES;
  localparam int BINS        = LIMIT_SLOTS + 2;
  localparam int QDEPTH      = 4;

  localparam int IDX_W  = 7;
  localparam int LIM_W  = 8;
  localparam int CNT_W  = 48;
  localparam int SUM_W  = 56;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int LANE_W = $clog2(LANES);
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // register map
  localparam logic REG_LIMIT_COUNT = 1'b0;

  // input commands
  localparam logic [1:0] CMD_LIMIT = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_ADD   = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // result status
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_AGE_OOR  = 2'd1;
  localparam logic [1:0] STAT_NOT_INC  = 2'd2;
  localparam logic [1:0] STAT_SLOT_OOR = 2'd3;

  // back-end operations
  localparam logic [2:0] OP_REPORT = 3'd0;  // result known at classify time
  localparam logic [2:0] OP_LIMIT  = 3'd1;
  localparam logic [2:0] OP_CLEAR  = 3'd2;
  localparam logic [2:0] OP_COUNT  = 3'd3;  // add, bin still to be found
  localparam logic [2:0] OP_UPDATE = 3'd4;  // add to a known bin
  localparam logic [2:0] OP_READ   = 3'd5;

  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef struct packed {
    logic [2:0]              op;
    logic [1:0]              status;
    logic [IDX_W-1:0]        bin;
    logic [LIM_W-1:0]        lim;
    logic [LIM_W-1:0]        age;
    logic signed [CNT_W-1:0] cnt;
    logic [IDX_W-1:0]        n;
  } job_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [IDX_W-1:0]        bin_number;
    logic [LIM_W-1:0]        lower;
    logic [LIM_W-1:0]        upper;
    logic                    open;
    logic                    missing;
    logic signed [SUM_W-1:0] sum;
  } res_t;

endpackage

`default_nettype wire

### rtl/variable_edge_histogram_core.sv
// Top level of the variable edge histogram: front end, job queue, back end.
// States per item: IDLE, START; add with age then COUNT over ceil(n/8) rows (n limits
// in use, one row of eight limits compared per cycle), DESC, SUM; add to missing bin
// or read DESC, SUM; limit LCHK; DONE loads the ports when no result waits there.
// Reset: limit_count = 1, all bin sums read as zero (valid bits clear at once),
// limit table undefined until written; no clearing pass, items accepted at once.
`default_nettype none

module variable_edge_histogram_core import vehist_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready,
  input  logic                    push,
  output logic                    full,
  input  logic [1:0]              cmd,
  input  logic [IDX_W-1:0]        slot_index,
  input  logic [LIM_W-1:0]        limit_value,
  input  logic [LIM_W-1:0]        age,
  input  logic                    age_missing,
  input  logic signed [CNT_W-1:0] count,
  output logic                    empty,
  input  logic                    pop,
  output logic [1:0]              status,
  output logic [IDX_W-1:0]        bin_number,
  output logic [LIM_W-1:0]        bin_lower,
  output logic [LIM_W-1:0]        bin_upper,
  output logic                    upper_open,
  output logic                    is_missing_bin,
  output logic signed [SUM_W-1:0] bin_sum
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  job_t q_in;
  job_t q_out;
  res_t res;

  vehist_front u_front (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .push        (push),
    .full        (full),
    .cmd         (cmd),
    .slot_index  (slot_index),
    .limit_value (limit_value),
    .age         (age),
    .age_missing (age_missing),
    .count       (count),
    .q_push      (q_push),
    .q_full      (q_full),
    .q_job       (q_in)
  );

  vehist_jobq u_jobq (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .dout  (q_out)
  );

  vehist_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_job   (q_out),
    .pop     (pop),
    .empty   (empty),
    .out_res (res)
  );

  assign status         = res.status;
  assign bin_number     = res.bin_number;
  assign bin_lower      = res.lower;
  assign bin_upper      = res.upper;
  assign upper_open     = res.open;
  assign is_missing_bin = res.missing;
  assign bin_sum        = res.sum;

endmodule

`default_nettype wire

### rtl/vehist_front.sv
// Front end: configuration register and classification of incoming items.
`default_nettype none

module vehist_front import vehist_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready,
  input  logic                    push,
  output logic                    full,
  input  logic [1:0]              cmd,
  input  logic [IDX_W-1:0]        slot_index,
  input  logic [LIM_W-1:0]        limit_value,
  input  logic [LIM_W-1:0]        age,
  input  logic                    age_missing,
  input  logic signed [CNT_W-1:0] count,
  output logic                    q_push,
  input  logic                    q_full,
  output job_t                    q_job
);

  logic [IDX_W-1:0] limit_count;
  logic [IDX_W-1:0] n_used;
  logic [IDX_W-1:0] n_p1;
  logic             reg_sel;

  assign reg_sel = (paddr[ADDR_W-1] == REG_LIMIT_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_count <= 7'd1;
    end else if (psel && penable && pwrite && reg_sel) begin
      limit_count <= pwdata[IDX_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = reg_sel ? {{(DATA_W-IDX_W){1'b0}}, limit_count} : '0;

  always_comb begin
    if (limit_count == '0) begin
      n_used = 7'd1;
    end else if (limit_count > IDX_W'(LIMIT_SLOTS)) begin
      n_used = IDX_W'(LIMIT_SLOTS);
    end else begin
      n_used = limit_count;
    end
  end

  assign n_p1 = n_used + 7'd1;

  always_comb begin
    q_job.op     = OP_REPORT;
    q_job.status = STAT_OK;
    q_job.bin    = '0;
    q_job.lim    = limit_value;
    q_job.age    = age;
    q_job.cnt    = count;
    q_job.n      = n_used;
    case (cmd)
      CMD_LIMIT: begin
        q_job.bin = slot_index;
        if (slot_index >= IDX_W'(LIMIT_SLOTS)) begin
          q_job.status = STAT_SLOT_OOR;
        end else begin
          q_job.op = OP_LIMIT;
        end
      end
      CMD_CLEAR: begin
        q_job.op = OP_CLEAR;
      end
      CMD_ADD: begin
        if (age_missing) begin
          q_job.op  = OP_UPDATE;
          q_job.bin = n_p1;
        end else if (32'(age) >= AGE_BOUND) begin
          q_job.status = STAT_AGE_OOR;
        end else begin
          q_job.op = OP_COUNT;
        end
      end
      default: begin
        q_job.bin = slot_index;
        if (slot_index > n_p1) begin
          q_job.status = STAT_SLOT_OOR;
        end else begin
          q_job.op = OP_READ;
        end
      end
    endcase
  end

  assign full   = q_full;
  assign q_push = push && !q_full;

endmodule

`default_nettype wire

### rtl/vehist_jobq.sv
// Short job queue between the front end and the back end.
`default_nettype none

module vehist_jobq import vehist_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t din,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t dout
);

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wp;
  logic [QPTR_W-1:0] rp;
  logic [QCNT_W-1:0] cnt;
  logic              do_push;
  logic              do_pop;

  assign full    = (cnt == QCNT_W'(QDEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= wp + 1'b1;
      end
      if (do_pop) begin
        rp <= rp + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= din;
    end
  end

endmodule

`default_nettype wire

### rtl/vehist_back.sv
// Back end: limit table, bin search, accumulators and the result register.
`default_nettype none
`include "assert_macros.svh"

module vehist_back import vehist_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic q_empty,
  output logic q_pop,
  input  job_t q_job,
  input  logic pop,
  output logic empty,
  output res_t out_res
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_LCHK  = 3'd2;
  localparam logic [2:0] ST_COUNT = 3'd3;
  localparam logic [2:0] ST_DESC  = 3'd4;
  localparam logic [2:0] ST_SUM   = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  job_t             job;
  logic [ROW_W-1:0] row;
  logic [IDX_W-1:0] kacc;
  res_t             res;
  res_t             res_next;
  logic             res_load;
  logic             out_valid;
  logic             out_load;

  // limit table: ROWS rows of LANES limits
  logic [LANES-1:0][LIM_W-1:0] lim_mem [ROWS];
  logic [LANES-1:0][LIM_W-1:0] rd_a;
  logic [LANES-1:0][LIM_W-1:0] rd_b;
  logic [ROW_W-1:0]            raddr_a;
  logic [ROW_W-1:0]            raddr_b;
  logic                        lim_we;

  // accumulators, a cleared entry reads as zero through its valid bit
  logic [SUM_W-1:0] sum_mem [BINS];
  logic [BINS-1:0]  sum_vld;
  logic [SUM_W-1:0] sum_rd;
  logic             sum_vld_rd;
  logic             sum_we;
  logic             vld_clear;

  logic [IDX_W-1:0]        bm1;
  logic [LIM_W-1:0]        prev_lim;
  logic                    lim_bad;
  logic [LANE_W:0]         pc;
  logic [IDX_W-1:0]        k_next;
  logic [IDX_W-1:0]        row_end;
  logic                    count_last;
  logic signed [SUM_W-1:0] old_sum;
  logic signed [SUM_W:0]   add_full;
  logic signed [SUM_W-1:0] sat_sum;
  logic                    is_open;
  logic                    is_miss;

  assign bm1      = job.bin - 7'd1;
  assign prev_lim = (job.bin == '0) ? '0 : rd_a[bm1[LANE_W-1:0]];
  assign lim_bad  = (job.lim <= prev_lim);

  always_comb begin
    pc = '0;
    for (int j = 0; j < LANES; j++) begin
      if ((rd_a[j] <= job.age) && ({1'b0, row, LANE_W'(j)} < job.n)) begin
        pc = pc + 1'b1;
      end
    end
  end

  assign k_next     = kacc + IDX_W'(pc);
  assign row_end    = {({1'b0, row} + 1'b1), {LANE_W{1'b0}}};
  assign count_last = (row_end >= job.n);

  assign old_sum  = sum_vld_rd ? sum_rd : '0;
  assign add_full = {old_sum[SUM_W-1], old_sum} +
                    {{(SUM_W+1-CNT_W){job.cnt[CNT_W-1]}}, job.cnt};
  always_comb begin
    if (add_full[SUM_W] != add_full[SUM_W-1]) begin
      sat_sum = add_full[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sat_sum = add_full[SUM_W-1:0];
    end
  end

  assign is_open = (job.bin == job.n);
  assign is_miss = (job.bin == job.n + 7'd1);

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    raddr_a    = bm1[LANE_W +: ROW_W];
    raddr_b    = job.bin[LANE_W +: ROW_W];
    lim_we     = 1'b0;
    sum_we     = 1'b0;
    vld_clear  = 1'b0;
    res_load   = 1'b0;
    res_next   = '0;
    res_next.status     = job.status;
    res_next.bin_number = job.bin;
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = ST_START;
        end
      end
      ST_START: begin
        case (job.op)
          OP_LIMIT: begin
            state_next = ST_LCHK;
          end
          OP_COUNT: begin
            raddr_a    = '0;
            state_next = ST_COUNT;
          end
          OP_UPDATE, OP_READ: begin
            state_next = ST_DESC;
          end
          OP_CLEAR: begin
            vld_clear  = 1'b1;
            res_load   = 1'b1;
            state_next = ST_DONE;
          end
          default: begin
            res_load   = 1'b1;
            state_next = ST_DONE;
          end
        endcase
      end
      ST_LCHK: begin
        lim_we          = !lim_bad;
        res_load        = 1'b1;
        res_next.status = lim_bad ? STAT_NOT_INC : STAT_OK;
        state_next      = ST_DONE;
      end
      ST_COUNT: begin
        raddr_a = row + 1'b1;
        if (count_last) begin
          state_next = ST_DESC;
        end
      end
      ST_DESC: begin
        state_next = ST_SUM;
      end
      ST_SUM: begin
        sum_we           = (job.op != OP_READ);
        res_load         = 1'b1;
        res_next.status  = STAT_OK;
        res_next.missing = is_miss;
        res_next.open    = is_open;
        res_next.lower   = (job.bin == '0 || is_miss) ? '0 : rd_a[bm1[LANE_W-1:0]];
        res_next.upper   = (is_open || is_miss) ? '0 : rd_b[job.bin[LANE_W-1:0]];
        res_next.sum     = (job.op == OP_READ) ? old_sum : sat_sum;
        state_next       = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || pop) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign out_load = (state == ST_DONE) && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      sum_vld   <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (vld_clear) begin
        sum_vld <= '0;
      end else if (sum_we) begin
        sum_vld[job.bin] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_job;
    end
    if (state == ST_START) begin
      row  <= '0;
      kacc <= '0;
    end else if (state == ST_COUNT) begin
      row  <= row + 1'b1;
      kacc <= k_next;
      if (count_last) begin
        job.bin <= k_next;
      end
    end
    if (res_load) begin
      res <= res_next;
    end
    if (out_load) begin
      out_res <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (lim_we) begin
      lim_mem[job.bin[LANE_W +: ROW_W]][job.bin[LANE_W-1:0]] <= job.lim;
    end
    rd_a <= lim_mem[raddr_a];
    rd_b <= lim_mem[raddr_b];
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[job.bin] <= sat_sum;
    end
    sum_rd     <= sum_mem[job.bin];
    sum_vld_rd <= sum_vld[job.bin];
  end

  assign empty = !out_valid;

  `ASSERT_NEXT(a_clear_drops_sums, (state == ST_START && job.op == OP_CLEAR), (sum_vld == '0), "clear left a bin marked valid")
  `ASSERT_IMPL(a_bin_in_range, (state == ST_SUM), (job.bin <= job.n + 7'd1), "bin beyond the missing bin")
  `ASSERT_IMPL(a_count_row_used, (state == ST_COUNT), ((IDX_W'(row) << LANE_W) < job.n), "search row past the limits in use")

endmodule

`default_nettype wire

### tb/vehist_checker.sv
// Histogram checker: predicts every result from the accepted items and compares.
`default_nettype none

module vehist_checker import vehist_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  input  logic [DATA_W-1:0]       prdata,
  input  logic                    pready,
  input  logic                    push,
  input  logic                    full,
  input  logic [1:0]              cmd,
  input  logic [IDX_W-1:0]        slot_index,
  input  logic [LIM_W-1:0]        limit_value,
  input  logic [LIM_W-1:0]        age,
  input  logic                    age_missing,
  input  logic signed [CNT_W-1:0] count,
  input  logic                    empty,
  input  logic                    pop,
  input  logic [1:0]              status,
  input  logic [IDX_W-1:0]        bin_number,
  input  logic [LIM_W-1:0]        bin_lower,
  input  logic [LIM_W-1:0]        bin_upper,
  input  logic                    upper_open,
  input  logic                    is_missing_bin,
  input  logic signed [SUM_W-1:0] bin_sum,
  output int                      errors,
  output int                      pending
);

  localparam logic [ADDR_W-1:0] CFG_ADDR = {REG_LIMIT_COUNT, 2'b00};
  localparam longint ACC_TOP = 64'sh007F_FFFF_FFFF_FFFF;
  localparam longint ACC_BOT = -ACC_TOP - 1;

  logic [LIM_W-1:0]        edge_tab [LIMIT_SLOTS];
  logic signed [SUM_W-1:0] acc_tab [BINS];
  logic [IDX_W-1:0]        edges_cfg;
  res_t                    awaited_bins [$];
  res_t                    want;

  function automatic res_t bin_report(int unsigned b, int unsigned n);
    res_t r;
    r = '0;
    r.bin_number = IDX_W'(b);
    r.sum = acc_tab[b];
    if (b == n + 1) begin
      r.missing = 1'b1;
    end else begin
      if (b > 0) r.lower = edge_tab[b-1];
      if (b == n) r.open = 1'b1;
      else r.upper = edge_tab[b];
    end
    return r;
  endfunction

  function automatic res_t bin_update(logic [1:0] c, logic [IDX_W-1:0] s,
                                      logic [LIM_W-1:0] lv, logic [LIM_W-1:0] a,
                                      logic m, logic signed [CNT_W-1:0] cnt);
    res_t r;
    int unsigned n;
    int unsigned k;
    longint acc;
    logic [LIM_W-1:0] prev;
    r = '0;
    // out-of-range limit counts clamp to 1..LIMIT_SLOTS
    if (edges_cfg == 0) n = 1;
    else if (edges_cfg > LIMIT_SLOTS) n = LIMIT_SLOTS;
    else n = edges_cfg;
    case (c)
      CMD_LIMIT: begin
        r.bin_number = s;
        if (s >= LIMIT_SLOTS) begin
          r.status = STAT_SLOT_OOR;
        end else begin
          prev = (s == 0) ? '0 : edge_tab[s-1];
          if (lv <= prev) r.status = STAT_NOT_INC;
          else edge_tab[s] = lv;
        end
      end
      CMD_CLEAR: begin
        foreach (acc_tab[i]) acc_tab[i] = '0;
      end
      CMD_ADD: begin
        if (!m && a >= AGE_BOUND) begin
          r.status = STAT_AGE_OOR;
        end else begin
          if (m) begin
            k = n + 1;
          end else begin
            k = 0;
            for (int i = 0; i < n; i++) if (edge_tab[i] <= a) k++;
          end
          acc = longint'(acc_tab[k]) + longint'(cnt);
          if (acc > ACC_TOP) acc = ACC_TOP;
          if (acc < ACC_BOT) acc = ACC_BOT;
          acc_tab[k] = acc[SUM_W-1:0];
          r = bin_report(k, n);
        end
      end
      default: begin
        if (s > n + 1) begin
          r.status = STAT_SLOT_OOR;
          r.bin_number = s;
        end else begin
          r = bin_report(s, n);
        end
      end
    endcase
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (acc_tab[i]) acc_tab[i] = '0;
      foreach (edge_tab[i]) edge_tab[i] = '0;
      edges_cfg = IDX_W'(1);
      awaited_bins.delete();
      errors = 0;
      pending = 0;
    end else begin
      if (psel && penable && pready && paddr == CFG_ADDR) begin
        if (pwrite) begin
          edges_cfg = pwdata[IDX_W-1:0];
        end else if (prdata !== DATA_W'(edges_cfg)) begin
          errors++;
          $display("%0t: limit_count readback, expected %h actual %h",
                   $time, DATA_W'(edges_cfg), prdata);
        end
      end
      if (pop && !empty) begin
        if (awaited_bins.size() == 0) begin
          errors++;
          $display("%0t: result with no item waiting, expected none actual bin %0d",
                   $time, bin_number);
        end else begin
          want = awaited_bins.pop_front();
          check_field("status", want.status, status);
          check_field("bin_number", want.bin_number, bin_number);
          check_field("bin_lower", want.lower, bin_lower);
          check_field("bin_upper", want.upper, bin_upper);
          check_field("upper_open", want.open, upper_open);
          check_field("is_missing_bin", want.missing, is_missing_bin);
          check_field("bin_sum", want.sum, bin_sum);
        end
      end
      if (push && !full)
        awaited_bins.push_back(bin_update(cmd, slot_index, limit_value, age,
                                          age_missing, count));
      pending = awaited_bins.size();
    end
  end

endmodule

`default_nettype wire

### tb/tb.sv
// Histogram testbench top: clock, reset, stimulus, idling and the verdict.
`default_nettype none

module tb;
  import vehist_pkg::*;

  localparam logic [ADDR_W-1:0] CFG_ADDR = {REG_LIMIT_COUNT, 2'b00};
  localparam logic [CNT_W-1:0]  CNT_HI   = {1'b0, {(CNT_W-1){1'b1}}};
  localparam logic [CNT_W-1:0]  CNT_LO   = {1'b1, {(CNT_W-1){1'b0}}};
  localparam int                PILE_LEN = 264;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [ADDR_W-1:0]       paddr = '0;
  logic [DATA_W-1:0]       pwdata = '0;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;
  logic                    push = 1'b0;
  logic                    full;
  logic [1:0]              cmd = CMD_CLEAR;
  logic [IDX_W-1:0]        slot_index = '0;
  logic [LIM_W-1:0]        limit_value = '0;
  logic [LIM_W-1:0]        age = '0;
  logic                    age_missing = 1'b0;
  logic signed [CNT_W-1:0] count = '0;
  logic                    empty;
  logic                    pop = 1'b0;
  logic [1:0]              status;
  logic [IDX_W-1:0]        bin_number;
  logic [LIM_W-1:0]        bin_lower;
  logic [LIM_W-1:0]        bin_upper;
  logic                    upper_open;
  logic                    is_missing_bin;
  logic signed [SUM_W-1:0] bin_sum;
  int                      errors;
  int                      pending;

  int               send_idle = 36;
  int               recv_idle = 49;
  int               used_n = 1;
  logic [LIM_W-1:0] edge_val [LIMIT_SLOTS];

  variable_edge_histogram_core i_dut (.*);
  vehist_checker i_checker (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) pop <= ($urandom_range(0, 99) >= recv_idle);

  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(logic [1:0] c, logic [IDX_W-1:0] s, logic [LIM_W-1:0] lv,
                           logic [LIM_W-1:0] a, logic m, logic [CNT_W-1:0] cnt);
    while ($urandom_range(0, 99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    cmd <= c;
    slot_index <= s;
    limit_value <= lv;
    age <= a;
    age_missing <= m;
    count <= cnt;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apb_cycle(logic wr, logic [DATA_W-1:0] d);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= CFG_ADDR;
    pwdata <= d;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_limit_count(int v);
    drain();
    apb_cycle(1'b1, DATA_W'(v));
    apb_cycle(1'b0, '0);
    if (v == 0) used_n = 1;
    else if (v > LIMIT_SLOTS) used_n = LIMIT_SLOTS;
    else used_n = v;
  endtask

  function automatic logic [CNT_W-1:0] pick_count();
    int p;
    p = $urandom_range(0, 99);
    if (p < 20) return CNT_HI;
    if (p < 40) return CNT_LO;
    if (p < 55) return CNT_W'(int'($urandom_range(0, 2000)) - 1000);
    return CNT_W'({$urandom, $urandom});
  endfunction

  // strictly increasing limits in slots 0..upto-1
  task automatic load_edges(int upto);
    int prev;
    int room;
    int hi;
    int v;
    prev = 0;
    for (int s = 0; s < upto; s++) begin
      room = 255 - (upto - 1 - s) - prev;
      hi = 2 * room / (upto - s);
      if (hi < 1) hi = 1;
      if (hi > room) hi = room;
      v = prev + $urandom_range(1, hi);
      edge_val[s] = LIM_W'(v);
      send_item(CMD_LIMIT, IDX_W'(s), LIM_W'(v), LIM_W'($urandom), 1'($urandom),
                CNT_W'({$urandom, $urandom}));
      prev = v;
    end
  endtask

  task automatic random_items(int num);
    int r;
    int p;
    int j;
    int a;
    logic [1:0] c;
    logic [IDX_W-1:0] s;
    logic [LIM_W-1:0] lv;
    logic [LIM_W-1:0] ag;
    logic m;
    logic [CNT_W-1:0] cnt;
    for (int i = 0; i < num; i++) begin
      s = IDX_W'($urandom);
      lv = LIM_W'($urandom);
      ag = LIM_W'($urandom);
      m = 1'($urandom);
      cnt = CNT_W'({$urandom, $urandom});
      r = $urandom_range(0, 99);
      if (r < 45) begin
        c = CMD_ADD;
        m = ($urandom_range(0, 99) < 15);
        p = $urandom_range(0, 99);
        if (p < 12) begin
          ag = LIM_W'($urandom_range(AGE_BOUND, 255));
        end else if (p < 50) begin
          // land on or just below a limit
          j = $urandom_range(0, used_n - 1);
          a = int'(edge_val[j]) - int'($urandom_range(0, 1));
          ag = (a < AGE_BOUND) ? LIM_W'(a) : LIM_W'($urandom_range(0, AGE_BOUND - 1));
        end else begin
          ag = LIM_W'($urandom_range(0, AGE_BOUND - 1));
        end
        cnt = pick_count();
      end else if (r < 72) begin
        c = CMD_READ;
        if ($urandom_range(0, 99) < 85) s = IDX_W'($urandom_range(0, used_n + 1));
      end else if (r < 95) begin
        c = CMD_LIMIT;
        if ($urandom_range(0, 99) < 85) s = IDX_W'($urandom_range(0, LIMIT_SLOTS - 1));
      end else begin
        c = CMD_CLEAR;
      end
      send_item(c, s, lv, ag, m, cnt);
    end
  endtask

  task automatic run_half(int n_cfg, int num);
    set_limit_count(n_cfg);
    if ($urandom_range(0, 1)) load_edges($urandom_range(1, 16));
    random_items(num / 2);
    drain();
    random_items(num - num / 2);
  endtask

  // drive one bin into saturation, peeking at it now and then
  task automatic pile_up(logic m, logic [CNT_W-1:0] cnt, int peek_bin);
    for (int i = 0; i < PILE_LEN; i++) begin
      if (i % 40 == 39)
        send_item(CMD_READ, IDX_W'(peek_bin), LIM_W'($urandom), LIM_W'($urandom),
                  1'($urandom), CNT_W'({$urandom, $urandom}));
      else
        send_item(CMD_ADD, IDX_W'($urandom), LIM_W'($urandom),
                  m ? LIM_W'($urandom) : '0, m, cnt);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset value of limit_count (one limit)
    send_item(CMD_LIMIT, 0, 50, 8'($urandom), 1'($urandom), 48'({$urandom, $urandom}));
    send_item(CMD_READ, 0, 8'($urandom), 8'($urandom), 1'($urandom), 48'($urandom));
    send_item(CMD_READ, 1, 8'($urandom), 8'($urandom), 1'($urandom), 48'($urandom));
    send_item(CMD_READ, 2, 8'($urandom), 8'($urandom), 1'($urandom), 48'($urandom));
    send_item(CMD_READ, 3, 8'($urandom), 8'($urandom), 1'($urandom), 48'($urandom));
    send_item(CMD_READ, 127, 8'($urandom), 8'($urandom), 1'($urandom), 48'($urandom));
    send_item(CMD_ADD, 7'($urandom), 8'($urandom), 0, 1'b0, CNT_HI);
    send_item(CMD_ADD, 7'($urandom), 8'($urandom), 49, 1'b0, CNT_LO);
    send_item(CMD_ADD, 7'($urandom), 8'($urandom), 50, 1'b0, CNT_LO);
    send_item(CMD_ADD, 7'($urandom), 8'($urandom), LIM_W'(AGE_BOUND - 1), 1'b0, 48'd1);
    send_item(CMD_ADD, 7'($urandom), 8'($urandom), LIM_W'(AGE_BOUND), 1'b0, CNT_HI);
    send_item(CMD_ADD, 7'($urandom), 8'($urandom), 255, 1'b0, CNT_HI);
    send_item(CMD_ADD, 7'($urandom), 8'($urandom), 255, 1'b1, 48'({$urandom, $urandom}));
    // limit writes: zero and equal to previous rejected, slot 1 set, slots out of range
    send_item(CMD_LIMIT, 0, 0, 8'($urandom), 1'($urandom), 48'($urandom));
    send_item(CMD_LIMIT, 1, 50, 8'($urandom), 1'($urandom), 48'($urandom));
    send_item(CMD_LIMIT, 1, 255, 8'($urandom), 1'($urandom), 48'($urandom));
    send_item(CMD_LIMIT, IDX_W'(LIMIT_SLOTS), 255, 8'($urandom), 1'($urandom),
              48'($urandom));
    send_item(CMD_LIMIT, 127, 255, 8'($urandom), 1'($urandom), 48'($urandom));
    // slot 0 overtakes slot 1: table no longer increasing
    send_item(CMD_LIMIT, 0, 255, 8'($urandom), 1'($urandom), 48'($urandom));
    send_item(CMD_CLEAR, 7'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
              48'($urandom));
    send_item(CMD_READ, 0, 8'($urandom), 8'($urandom), 1'($urandom), 48'($urandom));

    set_limit_count(2);
    send_item(CMD_ADD, 7'($urandom), 8'($urandom), LIM_W'(AGE_BOUND - 1), 1'b0,
              pick_count());
    send_item(CMD_READ, 1, 8'($urandom), 8'($urandom), 1'($urandom), 48'($urandom));
    send_item(CMD_READ, 2, 8'($urandom), 8'($urandom), 1'($urandom), 48'($urandom));
    send_item(CMD_READ, 3, 8'($urandom), 8'($urandom), 1'($urandom), 48'($urandom));
    send_item(CMD_ADD, 7'($urandom), 8'($urandom), 8'($urandom), 1'b1, pick_count());

    // zero limit count acts as one: bin 2 is the missing bin again
    set_limit_count(0);
    send_item(CMD_READ, 2, 8'($urandom), 8'($urandom), 1'($urandom), 48'($urandom));
    send_item(CMD_READ, 1, 8'($urandom), 8'($urandom), 1'($urandom), 48'($urandom));

    load_edges(LIMIT_SLOTS);
    // counts above the slot count act as the full table
    set_limit_count(127);
    send_item(CMD_READ, IDX_W'(LIMIT_SLOTS), 8'($urandom), 8'($urandom), 1'($urandom),
              48'($urandom));
    send_item(CMD_READ, IDX_W'(LIMIT_SLOTS + 1), 8'($urandom), 8'($urandom), 1'($urandom),
              48'($urandom));
    send_item(CMD_READ, IDX_W'(LIMIT_SLOTS + 2), 8'($urandom), 8'($urandom), 1'($urandom),
              48'($urandom));
    send_item(CMD_ADD, 7'($urandom), 8'($urandom), LIM_W'(AGE_BOUND - 1), 1'b0,
              pick_count());
    send_item(CMD_ADD, 7'($urandom), 8'($urandom), 8'($urandom), 1'b1, pick_count());

    run_half(LIMIT_SLOTS, 10);
    run_half(1, 10);

    send_idle = 49;
    recv_idle = 36;
    run_half($urandom_range(2, LIMIT_SLOTS - 1), 10);
    run_half(0, 10);

    send_idle = 0;
    recv_idle = 0;
    set_limit_count(127);
    send_item(CMD_CLEAR, 7'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
              48'($urandom));
    pile_up(1'b1, CNT_HI, LIMIT_SLOTS + 1);
    pile_up(1'b0, CNT_LO, 0);
    run_half($urandom_range(1, LIMIT_SLOTS), 10);

    drain();
    repeat (16) @(negedge clk);
    if (errors == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

### files.f
+incdir+rtl
rtl/vehist_pkg.sv
rtl/vehist_front.sv
rtl/vehist_jobq.sv
rtl/vehist_back.sv
rtl/variable_edge_histogram_core.sv
tb/vehist_checker.sv
tb/tb.sv
